/* design/shp_pkg.sv */
// shared types and constants for the 3x3 threshold sharpen block
package shp_pkg;

	localparam int PIXEL_W     = 16;
	localparam int STRENGTH_W  = 12;
	localparam int THRESH_W    = 16;
	localparam int GEOM_W      = 13;
	localparam int ROW_W       = 12;
	localparam int LAP_W       = 19;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	localparam int MIN_DIM          = 3;
	localparam int MAX_HEIGHT       = 4096;
	localparam int LINE_WIDTH_RST   = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam int STRENGTH_RST     = 256;
	localparam int THRESH_RST       = 65535;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_STRENGTH     = 3'd2,
		REG_THRESHOLD    = 3'd3
	} reg_idx_t;

	// what the control decides for one accepted item
	typedef struct packed {
		logic enter;
		logic res;
		logic drain;
		logic use_upper;
		logic border;
		logic frame_end;
	} dec_t;

endpackage

/* design/sharpen_3x3_threshold.sv */
// 3x3 cross sharpen with threshold, top level
// Streaming 3x3 cross sharpen. Pixels come in raster order, one per transfer, and each
// interior pixel at or below the threshold becomes c + s*(4c - up - down - left - right),
// rounded at the strength's binary point and clamped to 16 bits; border pixels and pixels
// above the threshold come out unchanged. The block takes one item every clock while the
// output is ready: the line stores are single-port-read RAMs read and written once per item.
// An accepted item goes from the line store read stage through the laplacian register and
// then the multiply and clamp into the result register. The input stalls only when the first
// stage holds an item that gives a result while the laplacian and result registers are both
// full and the output is not ready; items that give no result never wait on the output.
// Results lag the pixel stream by line_width + 1 pixels;
// at the end of a frame send line_width + 1 drain items (tuser high) to push out the rest.
// The line stores need no clearing pass: entries read before first being written only feed
// border pixels that pass through. The user must write configuration only while the block
// is idle (not enforced by the block); a geometry write restarts the raster positions.
module sharpen_3x3_threshold #(
	parameter int MAX_WIDTH = 4096,
	parameter int STRENGTH_FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [shp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [shp_pkg::CFG_DATA_W-1:0]   cfg_data,
	// pixel input
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [15:0]                      s_axis_tdata,   // [15:0] pixel_in
	input  logic                             s_axis_tuser,   // [0] drain
	// result output
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [15:0]                      m_axis_tdata,   // [15:0] pixel_out
	output logic                             m_axis_tlast    // frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);

	// control side
	logic                             accept;
	shp_pkg::dec_t                    dec;
	logic [AW-1:0]                    addr;
	logic [shp_pkg::STRENGTH_W-1:0]   strength;
	logic [shp_pkg::THRESH_W-1:0]     threshold;

	// stage 1: line store read data is here
	logic                             valid_s1;
	shp_pkg::dec_t                    dec_s1;
	logic [shp_pkg::PIXEL_W-1:0]      px_s1;
	logic [AW-1:0]                    addr_s1;
	logic [shp_pkg::PIXEL_W-1:0]      up_rdata;
	logic [shp_pkg::PIXEL_W-1:0]      mid_rdata;
	logic [shp_pkg::PIXEL_W-1:0]      center;
	logic signed [shp_pkg::LAP_W-1:0] lap;
	logic                             adv_s1;
	logic                             shift;
	logic                             sharp;
	logic [shp_pkg::PIXEL_W-1:0]      value;

	// stage 2: laplacian registered
	logic                             valid_s2;
	logic [shp_pkg::PIXEL_W-1:0]      value_s2;
	logic signed [shp_pkg::LAP_W-1:0] lap_s2;
	logic                             sharp_s2;
	logic                             last_s2;
	logic                             adv_s2;
	logic [shp_pkg::PIXEL_W-1:0]      pixel;

	// stage 3: result register
	logic                             valid_s3;
	logic [shp_pkg::PIXEL_W-1:0]      pixel_s3;
	logic                             last_s3;

	logic ready_s3;
	logic ready_s2;
	logic ready_s1;

	// each stage takes a new item when it is empty or handing its item on
	assign ready_s3 = !valid_s3 || m_axis_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign adv_s1   = valid_s1 && (!dec_s1.res || ready_s2);
	assign ready_s1 = !valid_s1 || adv_s1;
	assign adv_s2   = valid_s2 && ready_s3;

	assign s_axis_tready = ready_s1;
	assign accept        = s_axis_tvalid && ready_s1;

	shp_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.drain     (s_axis_tuser),
		.dec       (dec),
		.addr      (addr),
		.strength  (strength),
		.threshold (threshold)
	);

	// middle store is written when a pixel (not a drain) is accepted, upper store when the pixel leaves stage 1
	shp_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_lines (
		.clk       (clk),
		.rd_en     (accept && dec.enter),
		.rd_addr   (addr),
		.mid_we    (accept && !s_axis_tuser),
		.mid_wdata (s_axis_tdata),
		.up_we     (shift),
		.up_waddr  (addr_s1),
		.up_wdata  (mid_rdata),
		.up_rdata  (up_rdata),
		.mid_rdata (mid_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept && dec.enter;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && dec.enter) begin
			dec_s1  <= dec;
			px_s1   <= s_axis_tdata;
			addr_s1 <= addr;
		end
	end

	// window moves one column for every pixel, drains leave it alone
	assign shift = adv_s1 && !dec_s1.drain;

	shp_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.up_in  (up_rdata),
		.mid_in (mid_rdata),
		.px_in  (px_s1),
		.center (center),
		.lap    (lap)
	);

	// drains pass the pending pixel straight from a line store
	always_comb begin
		if (!dec_s1.drain) begin
			value = center;
		end else if (dec_s1.use_upper) begin
			value = up_rdata;
		end else begin
			value = mid_rdata;
		end
	end

	assign sharp = !dec_s1.drain && !dec_s1.border && (center <= threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= adv_s1 && dec_s1.res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && dec_s1.res) begin
			value_s2 <= value;
			lap_s2   <= lap;
			sharp_s2 <= sharp;
			last_s2  <= dec_s1.frame_end;
		end
	end

	shp_round #(
		.FRAC(STRENGTH_FRAC_BITS)
	) u_round (
		.strength (strength),
		.lap      (lap_s2),
		.value    (value_s2),
		.sharpen  (sharp_s2),
		.pixel    (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pixel_s3 <= pixel;
			last_s3  <= last_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = pixel_s3;
	assign m_axis_tlast  = last_s3;

endmodule

/* design/shp_line_store.sv */
// two line stores of original pixels with registered reads and write forwarding
module shp_line_store #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic                          mid_we,
	input  logic [shp_pkg::PIXEL_W-1:0]   mid_wdata,
	input  logic                          up_we,
	input  logic [$clog2(MAX_WIDTH)-1:0]  up_waddr,
	input  logic [shp_pkg::PIXEL_W-1:0]   up_wdata,
	output logic [shp_pkg::PIXEL_W-1:0]   up_rdata,
	output logic [shp_pkg::PIXEL_W-1:0]   mid_rdata
);

	logic [shp_pkg::PIXEL_W-1:0] upper_mem [MAX_WIDTH];
	logic [shp_pkg::PIXEL_W-1:0] middle_mem [MAX_WIDTH];
	logic [shp_pkg::PIXEL_W-1:0] up_rd_q;
	logic [shp_pkg::PIXEL_W-1:0] fwd_data_q;
	logic                        fwd_q;

	// middle store: read old value and write the new pixel at the same column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_rdata <= middle_mem[rd_addr];
		end
		if (mid_we) begin
			middle_mem[rd_addr] <= mid_wdata;
		end
	end

	// upper store is written one stage later, so a same-edge hit is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_rd_q    <= upper_mem[rd_addr];
			fwd_q      <= up_we && (up_waddr == rd_addr);
			fwd_data_q <= up_wdata;
		end
		if (up_we) begin
			upper_mem[up_waddr] <= up_wdata;
		end
	end

	assign up_rdata = fwd_q ? fwd_data_q : up_rd_q;

endmodule

/* design/shp_ctrl.sv */
// configuration registers, raster positions and per-item decisions
module shp_ctrl #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [shp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [shp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              accept,
	input  logic                              drain,
	output shp_pkg::dec_t                     dec,
	output logic [$clog2(MAX_WIDTH)-1:0]      addr,
	output logic [shp_pkg::STRENGTH_W-1:0]    strength,
	output logic [shp_pkg::THRESH_W-1:0]      threshold
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int RST_W = (shp_pkg::LINE_WIDTH_RST > MAX_WIDTH) ?
		MAX_WIDTH : shp_pkg::LINE_WIDTH_RST;

	logic [AW-1:0]                    wm1_q;
	logic [shp_pkg::ROW_W-1:0]        hm1_q;
	logic [shp_pkg::STRENGTH_W-1:0]   strength_q;
	logic [shp_pkg::THRESH_W-1:0]     thr_q;
	logic [AW-1:0]                    in_col_q;
	logic [AW-1:0]                    out_col_q;
	logic [shp_pkg::ROW_W-1:0]        in_row_q;
	logic [shp_pkg::ROW_W-1:0]        out_row_q;
	logic [PW-1:0]                    pend_q;

	logic [shp_pkg::GEOM_W-1:0] geom;
	logic [PW-1:0]              wp1;
	logic                       geom_wr;
	logic                       pend_full;
	logic                       res_dr;
	logic                       in_last_col;
	logic                       in_last_row;
	logic                       out_last_col;
	logic                       out_last_row;

	assign geom    = cfg_data[shp_pkg::GEOM_W-1:0];
	assign wp1     = PW'(wm1_q) + PW'(2);
	assign geom_wr = cfg_we && (cfg_index == shp_pkg::REG_LINE_WIDTH ||
		cfg_index == shp_pkg::REG_FRAME_HEIGHT);

	assign in_last_col  = (in_col_q == wm1_q);
	assign in_last_row  = (in_row_q == hm1_q);
	assign out_last_col = (out_col_q == wm1_q);
	assign out_last_row = (out_row_q == hm1_q);

	assign pend_full = (pend_q == wp1);
	// a drain only counts once the whole frame has come in
	assign res_dr = drain && (pend_q != '0) && (in_col_q == '0) && (in_row_q == '0);

	always_comb begin
		dec.enter     = !drain || res_dr;
		dec.res       = drain ? res_dr : pend_full;
		dec.drain     = drain;
		dec.use_upper = drain && pend_full;
		dec.border    = (out_row_q == '0) || out_last_row || (out_col_q == '0) || out_last_col;
		dec.frame_end = out_last_col && out_last_row;
	end

	always_comb begin
		if (dec.use_upper) begin
			addr = wm1_q;
		end else if (drain) begin
			addr = out_col_q;
		end else begin
			addr = in_col_q;
		end
	end

	assign strength  = strength_q;
	assign threshold = thr_q;

	// register file, geometry kept as clamped size minus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q      <= AW'(RST_W - 1);
			hm1_q      <= shp_pkg::ROW_W'(shp_pkg::FRAME_HEIGHT_RST - 1);
			strength_q <= shp_pkg::STRENGTH_W'(shp_pkg::STRENGTH_RST);
			thr_q      <= shp_pkg::THRESH_W'(shp_pkg::THRESH_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				shp_pkg::REG_LINE_WIDTH: begin
					if (int'(geom) < shp_pkg::MIN_DIM) begin
						wm1_q <= AW'(shp_pkg::MIN_DIM - 1);
					end else if (int'(geom) > MAX_WIDTH) begin
						wm1_q <= AW'(MAX_WIDTH - 1);
					end else begin
						wm1_q <= AW'(geom - shp_pkg::GEOM_W'(1));
					end
				end
				shp_pkg::REG_FRAME_HEIGHT: begin
					if (int'(geom) < shp_pkg::MIN_DIM) begin
						hm1_q <= shp_pkg::ROW_W'(shp_pkg::MIN_DIM - 1);
					end else if (int'(geom) > shp_pkg::MAX_HEIGHT) begin
						hm1_q <= shp_pkg::ROW_W'(shp_pkg::MAX_HEIGHT - 1);
					end else begin
						hm1_q <= shp_pkg::ROW_W'(geom - shp_pkg::GEOM_W'(1));
					end
				end
				shp_pkg::REG_STRENGTH: begin
					strength_q <= cfg_data[shp_pkg::STRENGTH_W-1:0];
				end
				shp_pkg::REG_THRESHOLD: begin
					thr_q <= cfg_data[shp_pkg::THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// positions and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (geom_wr) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (accept) begin
			if (!drain) begin
				if (in_last_col) begin
					in_col_q <= '0;
					in_row_q <= in_last_row ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (!pend_full) begin
					pend_q <= pend_q + 1'b1;
				end
			end else if (res_dr) begin
				pend_q <= pend_q - 1'b1;
			end
			if (dec.res) begin
				if (out_last_col) begin
					out_col_q <= '0;
					out_row_q <= out_last_row ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/shp_window.sv */
// cross window of original pixels and the laplacian of its center
module shp_window (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift,
	input  logic [shp_pkg::PIXEL_W-1:0]       up_in,
	input  logic [shp_pkg::PIXEL_W-1:0]       mid_in,
	input  logic [shp_pkg::PIXEL_W-1:0]       px_in,
	output logic [shp_pkg::PIXEL_W-1:0]       center,
	output logic signed [shp_pkg::LAP_W-1:0]  lap
);

	// previous column (top, middle, bottom) and middle row two columns back
	logic [shp_pkg::PIXEL_W-1:0] top_q;
	logic [shp_pkg::PIXEL_W-1:0] mid_q;
	logic [shp_pkg::PIXEL_W-1:0] bot_q;
	logic [shp_pkg::PIXEL_W-1:0] left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			mid_q  <= '0;
			bot_q  <= '0;
			left_q <= '0;
		end else if (shift) begin
			top_q  <= up_in;
			mid_q  <= mid_in;
			bot_q  <= px_in;
			left_q <= mid_q;
		end
	end

	// center is the previous middle pixel, right neighbour is the incoming one
	assign center = mid_q;
	assign lap = shp_pkg::LAP_W'({mid_q, 2'b00}) - shp_pkg::LAP_W'(top_q)
		- shp_pkg::LAP_W'(bot_q) - shp_pkg::LAP_W'(left_q) - shp_pkg::LAP_W'(mid_in);

endmodule

/* design/shp_round.sv */
// strength multiply, rounding and clamp of one sharpened pixel
module shp_round #(
	parameter int FRAC = 8
) (
	input  logic [shp_pkg::STRENGTH_W-1:0]    strength,
	input  logic signed [shp_pkg::LAP_W-1:0]  lap,
	input  logic [shp_pkg::PIXEL_W-1:0]       value,
	input  logic                              sharpen,
	output logic [shp_pkg::PIXEL_W-1:0]       pixel
);

	localparam int PROD_W = shp_pkg::STRENGTH_W + 1 + shp_pkg::LAP_W;
	localparam int BASE_W = shp_pkg::PIXEL_W + FRAC + 1;
	localparam int TW = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [TW-1:0]     sum;

	assign prod = $signed({1'b0, strength}) * lap;
	assign sum  = TW'(prod) + TW'({value, {FRAC{1'b0}}}) + (TW'(1) << (FRAC - 1));

	always_comb begin
		if (!sharpen) begin
			pixel = value;
		end else if (sum[TW-1]) begin
			pixel = '0;
		end else if (|sum[TW-2:FRAC+shp_pkg::PIXEL_W]) begin
			pixel = '1;
		end else begin
			pixel = sum[FRAC+shp_pkg::PIXEL_W-1:FRAC];
		end
	end

endmodule

/* tb/tb_sharpen_3x3_threshold.sv */
// testbench for the 3x3 cross sharpen with threshold, self-checking against a line-store model
`timescale 1ns / 1ps

module tb_sharpen_3x3_threshold;

	localparam int LINE_STORE_DEPTH = 4096;
	localparam int FRAC_BITS        = 8;
	localparam int PIXEL_LIMIT      = 65535;
	localparam int SETTLE_CYCLES    = 8;       // pipeline is three deep, leave some slack
	localparam int CYCLE_LIMIT      = 1500000;
	localparam int RANDOM_ITEMS     = 150;
	localparam int LARGE_ITEMS      = 48;

	// register indexes the block has no register behind
	localparam logic [shp_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [shp_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_HARSH} texture_t;
	typedef enum int {TAIL_FULL_DRAIN, TAIL_PART_DRAIN, TAIL_NO_DRAIN, TAIL_CUT_SHORT} tail_t;
	typedef enum int {SINK_OPEN, SINK_BUSY_LIGHT, SINK_BUSY_HEAVY, SINK_PULSED} sink_mode_t;

	typedef struct packed {
		logic [shp_pkg::PIXEL_W-1:0] pixel;
		logic                        frame_end;
	} pixel_result_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [shp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [15:0]                     s_axis_tdata = '0;   // [15:0] pixel_in
	logic                            s_axis_tuser = 1'b0; // [0] drain
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [15:0]                     m_axis_tdata;        // [15:0] pixel_out
	logic                            m_axis_tlast;        // frame_end

	sharpen_3x3_threshold dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor copy of the registers and the raster state
	logic [shp_pkg::GEOM_W-1:0]     cfg_width    =
		shp_pkg::GEOM_W'(shp_pkg::LINE_WIDTH_RST);
	logic [shp_pkg::GEOM_W-1:0]     cfg_height   =
		shp_pkg::GEOM_W'(shp_pkg::FRAME_HEIGHT_RST);
	logic [shp_pkg::STRENGTH_W-1:0] cfg_strength =
		shp_pkg::STRENGTH_W'(shp_pkg::STRENGTH_RST);
	logic [shp_pkg::THRESH_W-1:0]   cfg_thresh   =
		shp_pkg::THRESH_W'(shp_pkg::THRESH_RST);
	bit [shp_pkg::PIXEL_W-1:0]      upper_store [LINE_STORE_DEPTH];
	bit [shp_pkg::PIXEL_W-1:0]      mid_store [LINE_STORE_DEPTH];
	bit [shp_pkg::PIXEL_W-1:0]      win [3][3];
	int unsigned                    in_col, in_row, out_col, out_row, n_pending;

	pixel_result_t expected_pixels [$];
	int            mismatch_count = 0;
	int unsigned   stream_items = 0;
	int unsigned   burst_left = 0;
	int            hold_request = 0;
	int            hold_left = 0;
	int unsigned   sink_left = 0;
	sink_mode_t    sink_mode = SINK_OPEN;
	int unsigned   cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned active_width();
		if (cfg_width < shp_pkg::MIN_DIM) return shp_pkg::MIN_DIM;
		if (cfg_width > LINE_STORE_DEPTH) return LINE_STORE_DEPTH;
		return cfg_width;
	endfunction

	function automatic int unsigned active_height();
		if (cfg_height < shp_pkg::MIN_DIM) return shp_pkg::MIN_DIM;
		if (cfg_height > shp_pkg::MAX_HEIGHT) return shp_pkg::MAX_HEIGHT;
		return cfg_height;
	endfunction

	// work out the result, if any, that one accepted item causes
	task automatic predict_item(input logic [15:0] px, input logic drn);
		int unsigned   w, h, x;
		int            r;
		bit [15:0]     above, mid;
		longint        c, lap, acc;
		pixel_result_t res;
		w = active_width();
		h = active_height();
		if (drn) begin
			// drain counts only once the whole frame is in
			if (n_pending == 0 || in_col != 0 || in_row != 0) return;
			// what is left sits on the bottom row or the right column
			res.pixel = (n_pending >= w + 1) ? upper_store[w - 1] : mid_store[out_col];
			n_pending--;
		end else begin
			x = in_col;
			above = upper_store[x];
			mid = mid_store[x];
			upper_store[x] = mid;
			mid_store[x] = px;
			for (r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = above;
			win[1][2] = mid;
			win[2][2] = px;
			if (in_col + 1 >= w) begin
				in_col = 0;
				in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
			end else begin
				in_col++;
			end
			if (n_pending < w + 1) begin
				n_pending++;
				return;
			end
			if (out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w ||
					win[1][1] > cfg_thresh) begin
				res.pixel = win[1][1];
			end else begin
				c = longint'(win[1][1]);
				lap = 4 * c - longint'(win[0][1]) - longint'(win[2][1])
					- longint'(win[1][0]) - longint'(win[1][2]);
				acc = (c <<< FRAC_BITS) + longint'(cfg_strength) * lap
					+ (longint'(1) <<< (FRAC_BITS - 1));
				if (acc < 0)
					res.pixel = 16'd0;
				else if ((acc >>> FRAC_BITS) > PIXEL_LIMIT)
					res.pixel = 16'hFFFF;
				else
					res.pixel = acc[FRAC_BITS +: 16];
			end
		end
		res.frame_end = 1'b0;
		if (out_col + 1 >= w) begin
			out_col = 0;
			if (out_row + 1 >= h) begin
				out_row = 0;
				res.frame_end = 1'b1;
			end else begin
				out_row++;
			end
		end else begin
			out_col++;
		end
		expected_pixels.push_back(res);
	endtask

	// one input transfer, with bursts and random gaps in front
	task automatic send_item(input logic [15:0] px, input logic drn);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= drn;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_item(px, drn);
	endtask

	// sender goes quiet until every result is in and the pipeline is empty
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [shp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [shp_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			shp_pkg::REG_LINE_WIDTH:   cfg_width = val[shp_pkg::GEOM_W-1:0];
			shp_pkg::REG_FRAME_HEIGHT: cfg_height = val[shp_pkg::GEOM_W-1:0];
			shp_pkg::REG_STRENGTH:     cfg_strength = val[shp_pkg::STRENGTH_W-1:0];
			shp_pkg::REG_THRESHOLD:    cfg_thresh = val[shp_pkg::THRESH_W-1:0];
			default: ;
		endcase
		// geometry writes restart the raster, the stores keep their contents
		if (idx == shp_pkg::REG_LINE_WIDTH || idx == shp_pkg::REG_FRAME_HEIGHT) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			n_pending = 0;
		end
	endtask

	task automatic set_geometry(input logic [shp_pkg::CFG_DATA_W-1:0] w,
			input logic [shp_pkg::CFG_DATA_W-1:0] h);
		write_reg(shp_pkg::REG_LINE_WIDTH, w);
		write_reg(shp_pkg::REG_FRAME_HEIGHT, h);
	endtask

	// one frame of pixels at the current geometry, then its drain tail
	task automatic send_frame(input texture_t tex, input tail_t tail, input int noise_pct);
		int unsigned w, h, count, n;
		int          v;
		logic [15:0] base, px;
		w = active_width();
		h = active_height();
		count = w * h;
		if (tail == TAIL_CUT_SHORT)
			count = $urandom_range(1, count - 1);
		base = 16'($urandom);
		for (n = 0; n < count; n++) begin
			// stray drain in mid frame, the block ignores it
			if (n != 0 && $urandom_range(0, 99) < noise_pct)
				send_item(16'($urandom), 1'b1);
			case (tex)
				TEX_SMOOTH: begin
					v = int'(base) + int'($urandom_range(0, 600)) - 300;
					px = (v < 0) ? 16'd0 : (v > PIXEL_LIMIT) ? 16'hFFFF : 16'(v);
				end
				TEX_HARSH: begin
					case ($urandom_range(0, 3))
						0: px = 16'd0;
						1: px = 16'hFFFF;
						default: px = 16'($urandom);
					endcase
				end
				default: px = 16'($urandom);
			endcase
			send_item(px, 1'b0);
			stream_items++;
		end
		case (tail)
			TAIL_FULL_DRAIN: n = w + 1;
			TAIL_PART_DRAIN: n = $urandom_range(1, w);
			default:         n = 0;
		endcase
		repeat (n) send_item(16'($urandom), 1'b1);
		stream_items += n;
	endtask

	// drains with nothing pending, then a partial row at reset geometry
	task automatic test_reset_state();
		repeat (2) send_item(16'hFFFF, 1'b1);
		repeat (20) send_item(16'($urandom), 1'b0);
		send_item(16'h0000, 1'b1);
		wait_results();
	endtask

	// small frame with saturating pixels at full strength
	task automatic test_directed_frame();
		logic [15:0] pattern [16] = '{
			16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
		int n;
		set_geometry(16'd4, 16'd4);
		write_reg(shp_pkg::REG_STRENGTH, 16'd4095);
		write_reg(shp_pkg::REG_THRESHOLD, 16'hFFFF);
		for (n = 0; n < 16; n++) begin
			if (n == 5)
				send_item(16'hFFFF, 1'b1);
			send_item(pattern[n], 1'b0);
		end
		repeat (6) send_item(16'h0000, 1'b1);  // last one finds nothing pending
		wait_results();
	endtask

	// clamped geometry, masked register bits, threshold above and below pixels
	task automatic test_threshold_clamp();
		set_geometry(16'hE000, 16'd2);
		write_reg(shp_pkg::REG_STRENGTH, 16'hF080);
		write_reg(shp_pkg::REG_THRESHOLD, 16'h8000);
		repeat (3) send_frame(TEX_HARSH, TAIL_FULL_DRAIN, 0);
		wait_results();
		set_geometry(16'hE00A, 16'd5);
		write_reg(shp_pkg::REG_STRENGTH, 16'd0);
		write_reg(shp_pkg::REG_THRESHOLD, 16'h7FFF);
		send_frame(TEX_NOISE, TAIL_FULL_DRAIN, 0);
		wait_results();
		write_reg(shp_pkg::REG_STRENGTH, 16'd4095);
		write_reg(shp_pkg::REG_THRESHOLD, 16'd0);
		send_frame(TEX_HARSH, TAIL_FULL_DRAIN, 0);
		wait_results();
	endtask

	// partial drain then the stream carries on, writes to spare indexes
	task automatic test_partial_drain();
		set_geometry(16'd6, 16'd3);
		write_reg(shp_pkg::REG_STRENGTH, 16'd384);
		write_reg(shp_pkg::REG_THRESHOLD, 16'hFFFF);
		send_frame(TEX_SMOOTH, TAIL_PART_DRAIN, 0);
		send_frame(TEX_SMOOTH, TAIL_NO_DRAIN, 0);
		send_frame(TEX_NOISE, TAIL_FULL_DRAIN, 0);
		repeat (2) send_item(16'h5A5A, 1'b1);
		wait_results();
		write_reg(REG_SPARE_LO, 16'h0000);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		send_frame(TEX_SMOOTH, TAIL_FULL_DRAIN, 0);
		wait_results();
	endtask

	// random settings per phase, a few frames each with random tails
	task automatic test_random_frames(input int unsigned target);
		int unsigned phase, frames, f, w, h;
		logic [15:0] strength_val, thresh_val;
		tail_t       tail;
		phase = 0;
		stream_items = 0;
		while (phase < 2 || stream_items < target) begin
			if (phase <= 1 || $urandom_range(0, 9) < 7) begin
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(3, 10);
				if ($urandom_range(0, 9) == 0)
					w = $urandom_range(0, 2);
				h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
				if (phase == 1) begin
					w = 8;
					h = 6;
				end
				set_geometry(16'(w), 16'(h));
			end
			case ($urandom_range(0, 4))
				0: strength_val = 16'd0;
				1: strength_val = 16'd4095;
				2: strength_val = 16'd256;
				default: strength_val = 16'($urandom_range(0, 4095));
			endcase
			if ($urandom_range(0, 3) == 0)
				strength_val |= 16'hF000;
			case ($urandom_range(0, 3))
				0: thresh_val = 16'hFFFF;
				1: thresh_val = 16'd0;
				2: thresh_val = 16'($urandom_range(0, 4095));
				default: thresh_val = 16'($urandom);
			endcase
			write_reg(shp_pkg::REG_STRENGTH, strength_val);
			write_reg(shp_pkg::REG_THRESHOLD, thresh_val);
			// long receiver stall so the pipeline backs up onto the input
			if (phase == 1)
				hold_request = 400;
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				if (f + 1 == frames)
					tail = ($urandom_range(0, 6) == 0) ? TAIL_CUT_SHORT : TAIL_FULL_DRAIN;
				else
					tail = tail_t'($urandom_range(0, 2));
				send_frame(texture_t'($urandom_range(0, 2)), tail, 6);
			end
			wait_results();
			phase++;
		end
	endtask

	// widest line and tallest frame, first pixels of each only
	task automatic test_large_frames();
		set_geometry(16'd4096, 16'd3);
		write_reg(shp_pkg::REG_STRENGTH, 16'($urandom_range(0, 4095)));
		write_reg(shp_pkg::REG_THRESHOLD, 16'($urandom));
		repeat (LARGE_ITEMS) send_item(16'($urandom), 1'b0);
		send_item(16'h0000, 1'b1);
		wait_results();
		set_geometry(16'd3, 16'hFFFF);
		write_reg(shp_pkg::REG_STRENGTH, 16'd512);
		write_reg(shp_pkg::REG_THRESHOLD, 16'hFFFF);
		// rows stay well short of the clamped height, no frame end may show up
		repeat (LARGE_ITEMS) send_item(16'($urandom), 1'b0);
		wait_results();
	endtask

	// receiver: segments of random stall patterns, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (sink_left == 0) begin
				sink_left = $urandom_range(16, 160);
				sink_mode = sink_mode_t'($urandom_range(0, 3));
			end
			sink_left--;
			case (sink_mode)
				SINK_OPEN:       m_axis_tready <= 1'b1;
				SINK_BUSY_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
				SINK_BUSY_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:         m_axis_tready <= sink_left[2];
			endcase
		end
	end

	// every result transfer against the oldest expectation
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected result: pixel_out %0d frame_end %0b", m_axis_tdata,
					m_axis_tlast);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_axis_tdata !== want.pixel) begin
					$error("pixel_out expected %0d actual %0d", want.pixel, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== want.frame_end) begin
					$error("frame_end expected %0b actual %0b", want.frame_end, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_frame();
		test_threshold_clamp();
		test_partial_drain();
		test_random_frames(RANDOM_ITEMS);
		test_large_frames();
		wait_results();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
